// File: src/sorted_record_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Sorted record table: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_UNIT_ASSERT_SVH
`define SORTED_RECORD_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/srt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted record table: package
// Sizes, codes, controller command and datapath status types, string form.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BYTES   = 8;
  localparam int NAME_BYTES  = 8;
  localparam int VALUE_BYTES = 8;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_CNT_W = 7;
  localparam int EXT_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_MISSING = 3'd2,
    ST_NAME    = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    RD_MID = 2'd0,
    RD_POS = 2'd1,
    RD_CUR = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] name;
    logic [63:0] value;
  } record_t;

  typedef struct packed {
    logic    in_ready;
    logic    search_step;
    rd_sel_t rd_sel;
    logic    cur_load_up;
    logic    cur_load_dn;
    logic    shift_up;
    logic    shift_dn;
    logic    put_record;
    logic    count_inc;
    logic    count_dec;
    logic    load_result;
    status_t result_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] cmd;
    logic       lo_lt_hi;
    logic       key_lt;
    logic       key_eq;
    logic       name_eq;
    logic       pos_lt_cnt;
    logic       pos_next_lt_cnt;
    logic       full;
    logic       cur_at_pos;
    logic       cur_at_end;
    logic       out_free;
  } dp_status_t;

  // Keep the first nbytes bytes, clear all bytes from the first zero byte on.
  function automatic logic [63:0] canon(logic [63:0] v, int unsigned nbytes);
    logic [63:0] r;
    logic        live;
    logic [7:0]  b;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      b = v[63 - 8 * i -: 8];
      if (i >= nbytes || b == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        r[63 - 8 * i -: 8] = b;
      end
    end
    return r;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] count_out(logic [CNT_W-1:0] c);
    logic [EXT_W-1:0] w;
    w = EXT_W'(c);
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

// File: src/srt_req_if.sv
// ----------------------------------------------------------------------------
// Sorted record table: request channel
// Valid/ready channel carrying one table operation.
// ----------------------------------------------------------------------------
interface srt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] key;
  logic [63:0] name_text;
  logic [63:0] value_text;

  modport source (output valid, output cmd, output key, output name_text,
                  output value_text, input ready);
  modport sink   (input valid, input cmd, input key, input name_text,
                  input value_text, output ready);
endinterface

// File: src/srt_rsp_if.sv
// ----------------------------------------------------------------------------
// Sorted record table: response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface srt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// File: src/sorted_record_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted record table unit
// Key-sorted table of key/name/value records with insert, update and delete.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          result
//  req      in   cmd, key, name_text, value_text  one transfer on rsp each
//  rsp      out  status, entry_count              -
//
//  Per item: an idle state, a search and a compare state per binary search
//  step, a search state to address the found slot and a probe. Records are
//  moved one per cycle by insert and delete, then the drain state follows;
//  record writes go through the place state, and every item ends in done.
//  Reset clears the count, no records; no clearing pass. A waiting result does not
//  block the next req transfer, only the hand-off of the following result.
// ----------------------------------------------------------------------------
module sorted_record_table_unit (
  input  logic      clk,
  input  logic      rst,
  srt_req_if.sink   req,
  srt_rsp_if.source rsp
);
  import srt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  srt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  srt_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

// File: src/srt_datapath.sv
// ----------------------------------------------------------------------------
// Sorted record table: datapath
// Record memory, search bounds, shift cursor, record count and result register.
// ----------------------------------------------------------------------------
module srt_datapath (
  input  logic                  clk,
  input  logic                  rst,
  srt_req_if.sink               req,
  srt_rsp_if.source             rsp,
  input  srt_pkg::ctrl_cmd_t    cmd,
  output srt_pkg::dp_status_t   stat
);
  import srt_pkg::*;

  record_t          mem [TABLE_DEPTH];
  record_t          rd_data;
  record_t          wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  logic [1:0]       op;
  logic [63:0]      k;
  logic [63:0]      nm;
  logic [63:0]      val;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] count;
  logic             pend;
  logic [IDX_W-1:0] pend_dst;

  logic             out_valid;
  status_t          out_status;
  logic [CNT_W-1:0] out_count;
  logic             accept;

  assign req.ready = cmd.in_ready;
  assign accept    = req.valid && cmd.in_ready;
  assign mid       = lo + ((hi - lo) >> 1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_MID:  rd_addr = mid[IDX_W-1:0];
      RD_POS:  rd_addr = lo[IDX_W-1:0];
      RD_CUR:  rd_addr = cur[IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  assign wr_en   = pend || cmd.put_record;
  assign wr_addr = pend ? pend_dst : lo[IDX_W-1:0];
  assign wr_data = pend ? rd_data : record_t'{key: k, name: nm, value: val};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.cmd;
      k   <= canon(req.key, KEY_BYTES);
      nm  <= canon(req.name_text, NAME_BYTES);
      val <= canon(req.value_text, VALUE_BYTES);
      lo  <= '0;
      hi  <= count;
    end else if (cmd.search_step) begin
      if (rd_data.key < k) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.cur_load_up) begin
      cur <= count - 1'b1;
    end else if (cmd.cur_load_dn) begin
      cur <= lo + 1'b1;
    end else if (cmd.shift_up) begin
      cur      <= cur - 1'b1;
      pend_dst <= IDX_W'(cur + 1'b1);
    end else if (cmd.shift_dn) begin
      cur      <= cur + 1'b1;
      pend_dst <= IDX_W'(cur - 1'b1);
    end
    if (cmd.load_result) begin
      out_status <= cmd.result_status;
      out_count  <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.shift_up || cmd.shift_dn;
      if (cmd.count_inc) begin
        count <= count + 1'b1;
      end else if (cmd.count_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = count_out(out_count);

  always_comb begin
    stat                 = '0;
    stat.accepted        = accept;
    stat.cmd             = op;
    stat.lo_lt_hi        = lo < hi;
    stat.key_lt          = rd_data.key < k;
    stat.key_eq          = rd_data.key == k;
    stat.name_eq         = rd_data.name == nm;
    stat.pos_lt_cnt      = lo < count;
    stat.pos_next_lt_cnt = ({1'b0, lo} + 1'b1) < {1'b0, count};
    stat.full            = count == CNT_W'(TABLE_DEPTH);
    stat.cur_at_pos      = cur == lo;
    stat.cur_at_end      = ({1'b0, cur} + 1'b1) == {1'b0, count};
    stat.out_free        = !out_valid || rsp.ready;
  end

`include "sorted_record_table_unit_assert.svh"

  `SRT_ASSERT_IMPL(a_inc_not_full, cmd.count_inc, count < CNT_W'(TABLE_DEPTH), "insert into full table")
  `SRT_ASSERT_IMPL(a_dec_not_empty, cmd.count_dec, count != '0, "delete from empty table")
  `SRT_ASSERT_IMPL(a_one_write, cmd.put_record, !pend, "record write collides with shift write")
  `SRT_ASSERT_IMPL(a_result_slot, cmd.load_result, !out_valid || rsp.ready, "result overwritten")
  `SRT_ASSERT_NEXT(a_count_hold, !cmd.count_inc && !cmd.count_dec, $stable(count), "count moved")

endmodule

// File: src/srt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted record table: controller
// Sequences search, probe, shift, record write and result hand-off.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  srt_pkg::dp_status_t  stat,
  output srt_pkg::ctrl_cmd_t   cmd
);
  import srt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SEARCH   = 9'b000000010,
    S_CMP      = 9'b000000100,
    S_PROBE    = 9'b000001000,
    S_SHIFT_UP = 9'b000010000,
    S_SHIFT_DN = 9'b000100000,
    S_DRAIN    = 9'b001000000,
    S_PLACE    = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t result_code;
  status_t result_code_next;
  logic    found;

  assign found = stat.pos_lt_cnt && stat.key_eq;

  always_comb begin
    state_next       = state;
    result_code_next = result_code;
    cmd              = '0;
    cmd.rd_sel       = RD_MID;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.accepted) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_sel = RD_MID;
          state_next = S_CMP;
        end else begin
          cmd.rd_sel = RD_POS;
          state_next = S_PROBE;
        end
      end
      S_CMP: begin
        cmd.search_step = 1'b1;
        state_next      = S_SEARCH;
      end
      S_PROBE: begin
        result_code_next = ST_OK;
        state_next       = S_DONE;
        case (stat.cmd)
          OP_INSERT: begin
            if (found) begin
              result_code_next = ST_DUP;
            end else if (stat.full) begin
              result_code_next = ST_FULL;
            end else if (stat.pos_lt_cnt) begin
              cmd.cur_load_up = 1'b1;
              state_next      = S_SHIFT_UP;
            end else begin
              state_next = S_PLACE;
            end
          end
          OP_UPDATE: begin
            if (!found) begin
              result_code_next = ST_MISSING;
            end else if (!stat.name_eq) begin
              result_code_next = ST_NAME;
            end else begin
              state_next = S_PLACE;
            end
          end
          OP_DELETE: begin
            if (!found) begin
              result_code_next = ST_MISSING;
            end else if (stat.pos_next_lt_cnt) begin
              cmd.cur_load_dn = 1'b1;
              state_next      = S_SHIFT_DN;
            end else begin
              cmd.count_dec = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_UP: begin
        cmd.rd_sel   = RD_CUR;
        cmd.shift_up = 1'b1;
        if (stat.cur_at_pos) begin
          state_next = S_DRAIN;
        end
      end
      S_SHIFT_DN: begin
        cmd.rd_sel   = RD_CUR;
        cmd.shift_dn = 1'b1;
        if (stat.cur_at_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.cmd == OP_INSERT) begin
          state_next = S_PLACE;
        end else begin
          cmd.count_dec = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_PLACE: begin
        cmd.put_record = 1'b1;
        cmd.count_inc  = stat.cmd == OP_INSERT;
        state_next     = S_DONE;
      end
      S_DONE: begin
        cmd.result_status = result_code;
        if (stat.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    result_code <= result_code_next;
  end

endmodule

// File: dv/sorted_record_table_unit_test.sv
// ----------------------------------------------------------------------------
// Sorted record table unit: testbench
// Drives insert, update, delete and spare-code operations over the request
// channel, mirrors the sorted table in a local model and checks the status and
// record count of every response transfer in order. Directed corner cases come
// first, then fill and drain rounds drawn from a shared key pool, with random
// gaps on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module sorted_record_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int KEY_POOL = 96;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [63:0] name_text;
    logic [63:0] value_text;
  } request_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  srt_req_if req_ch ();
  srt_rsp_if rsp_ch ();

  sorted_record_table_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  request_t    pending_q [$];
  outcome_t    outcome_q [$];
  logic [63:0] tbl_key   [TABLE_DEPTH];
  logic [63:0] tbl_name  [TABLE_DEPTH];
  logic [63:0] tbl_value [TABLE_DEPTH];
  int          held = 0;
  logic [63:0] key_pool  [KEY_POOL];
  logic [63:0] name_pool [3];

  bit req_took = 1'b0;
  int requests_taken = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bytes up to the terminator, limited to width_bytes.
  function automatic logic [63:0] string_form(input logic [63:0] text, input int width_bytes);
    int live;
    live = 0;
    while (live < width_bytes && text[63 - 8 * live -: 8] != 8'h00) live++;
    return text & ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * live));
  endfunction

  // Random junk after the terminator; the string itself is unchanged.
  function automatic logic [63:0] smear_tail(input logic [63:0] text);
    int live;
    logic [63:0] junk_mask;
    live = 0;
    while (live < 8 && text[63 - 8 * live -: 8] != 8'h00) live++;
    if (live >= 7 || $urandom_range(0, 1) == 0) return text;
    junk_mask = (64'd1 << (8 * (7 - live))) - 64'd1;
    return text | ({$urandom, $urandom} & junk_mask);
  endfunction

  function automatic outcome_t apply_table_op(input logic [1:0] op, input logic [63:0] raw_key,
                                              input logic [63:0] raw_name,
                                              input logic [63:0] raw_value);
    logic [63:0] k;
    logic [63:0] n;
    logic [63:0] v;
    int slot;
    bit hit;
    outcome_t res;
    k = string_form(raw_key, KEY_BYTES);
    n = string_form(raw_name, NAME_BYTES);
    v = string_form(raw_value, VALUE_BYTES);
    slot = 0;
    while (slot < held && tbl_key[slot] < k) slot++;
    hit = slot < held && tbl_key[slot] == k;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (hit) begin
          res.status = ST_DUP;
        end else if (held >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = held; i > slot; i--) begin
            tbl_key[i]   = tbl_key[i - 1];
            tbl_name[i]  = tbl_name[i - 1];
            tbl_value[i] = tbl_value[i - 1];
          end
          tbl_key[slot]   = k;
          tbl_name[slot]  = n;
          tbl_value[slot] = v;
          held++;
        end
      end
      OP_UPDATE: begin
        if (!hit) res.status = ST_MISSING;
        else if (tbl_name[slot] != n) res.status = ST_NAME;
        else tbl_value[slot] = v;
      end
      OP_DELETE: begin
        if (!hit) begin
          res.status = ST_MISSING;
        end else begin
          for (int i = slot; i < held - 1; i++) begin
            tbl_key[i]   = tbl_key[i + 1];
            tbl_name[i]  = tbl_name[i + 1];
            tbl_value[i] = tbl_value[i + 1];
          end
          held--;
        end
      end
      default: ;
    endcase
    res.count = 7'(held);
    return res;
  endfunction

  function automatic request_t random_request(input bit filling);
    request_t r;
    int roll;
    roll = $urandom_range(0, 99);
    r.key = smear_tail(key_pool[$urandom_range(0, KEY_POOL - 1)]);
    r.name_text = smear_tail(name_pool[$urandom_range(0, 2)]);
    r.value_text = {$urandom, $urandom};
    if (roll < 4) begin
      r.cmd = 2'($urandom_range(0, 3));
      r.key = {$urandom, $urandom};
      r.name_text = {$urandom, $urandom};
    end else if (roll < 6) begin
      r.cmd = OP_SPARE;
    end else if (filling) begin
      r.cmd = (roll < 72) ? OP_INSERT : (roll < 88) ? OP_UPDATE : OP_DELETE;
    end else begin
      r.cmd = (roll < 25) ? OP_INSERT : (roll < 45) ? OP_UPDATE : OP_DELETE;
    end
    return r;
  endfunction

  task automatic queue_op(input logic [1:0] op, input logic [63:0] k, input logic [63:0] n,
                          input logic [63:0] v);
    pending_q.push_back('{cmd: op, key: k, name_text: n, value_text: v});
  endtask

  // Request driver
  always @(negedge clk) begin : drive_req
    request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_took) begin
      if (pending_q.size() != 0 &&
          ((requests_taken >= 350 && requests_taken < 500) || $urandom_range(0, 99) >= 15)) begin
        nxt = pending_q.pop_front();
        req_ch.cmd        <= nxt.cmd;
        req_ch.key        <= nxt.key;
        req_ch.name_text  <= nxt.name_text;
        req_ch.value_text <= nxt.value_text;
        req_ch.valid      <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response acceptor, with one long hold-off to back the table up
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 120) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp_ch.ready <= (results_seen >= 350 && results_seen < 500) ||
                      $urandom_range(0, 99) >= 15;
    end
  end

  // Monitor
  always @(posedge clk) begin : watch
    outcome_t want;
    req_took <= !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen <= results_seen + 1;
        if (outcome_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result status %0d count %0d", $time,
                     rsp_ch.status, rsp_ch.entry_count);
        end else begin
          want = outcome_q.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.entry_count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: result %0d: status %0d count %0d, expected status %0d count %0d",
                       $time, results_seen, rsp_ch.status, rsp_ch.entry_count,
                       want.status, want.count);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        outcome_q.push_back(apply_table_op(req_ch.cmd, req_ch.key, req_ch.name_text,
                                           req_ch.value_text));
        requests_taken <= requests_taken + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] text;
    int len;
    req_ch.valid = 1'b0;
    req_ch.cmd = OP_INSERT;
    req_ch.key = '0;
    req_ch.name_text = '0;
    req_ch.value_text = '0;
    rsp_ch.ready = 1'b0;

    name_pool[0] = 64'h616C_7068_6100_0000;
    name_pool[1] = 64'h6265_7461_0000_0000;
    name_pool[2] = 64'h6761_6D6D_6100_0000;
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool[2] = 64'h0100_0000_0000_0000;
    key_pool[3] = 64'h0000_0000_0000_0001;
    key_pool[4] = 64'h7FFF_FFFF_FFFF_FFFF;
    key_pool[5] = 64'h8000_0000_0000_0000;
    for (int i = 6; i < KEY_POOL; i++) begin
      text = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) text[63 - 8 * b -: 8] = 8'($urandom_range(1, 255));
      key_pool[i] = text;
    end

    // empty table, extremes, junk after terminators, duplicates, names
    queue_op(OP_DELETE, 64'h4B45_5900_0000_0000, name_pool[0], '1);
    queue_op(OP_UPDATE, 64'h4B45_5900_0000_0000, name_pool[0], '1);
    queue_op(OP_INSERT, 64'h0, name_pool[0], '1);
    queue_op(OP_INSERT, '1, name_pool[1], '0);
    queue_op(OP_INSERT, 64'h4100_DEAD_BEEF_0123, name_pool[2], 64'h5600_0000_0000_0000);
    queue_op(OP_INSERT, 64'h4100_0000_0000_0001, name_pool[0], '0);
    queue_op(OP_INSERT, 64'h0000_0000_0000_00FF, name_pool[1], '0);
    queue_op(OP_UPDATE, 64'h4100_0000_0000_0000, name_pool[0], '1);
    queue_op(OP_UPDATE, 64'h41FF_FFFF_FFFF_FFFF & 64'h4100_FFFF_FFFF_FFFF,
             64'h6761_6D6D_6100_77FF, '1);
    queue_op(OP_UPDATE, '1, name_pool[1], '1);
    queue_op(OP_SPARE, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    queue_op(OP_INSERT, 64'h8000_0000_0000_0000, name_pool[0], '0);
    queue_op(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, name_pool[1], '0);
    queue_op(OP_INSERT, 64'h0100_0000_0000_0000, name_pool[2], '1);
    queue_op(OP_DELETE, '1, '1, '1);
    queue_op(OP_DELETE, '1, '0, '0);
    queue_op(OP_DELETE, 64'h0, '0, '0);
    queue_op(OP_DELETE, 64'h8000_0000_0000_0000, '0, '0);
    queue_op(OP_UPDATE, 64'h7FFF_FFFF_FFFF_FFFF, name_pool[0], '0);
    queue_op(OP_DELETE, 64'h4100_0000_0000_0000, '1, '1);
    queue_op(OP_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 64'h0, 64'h0);
    queue_op(OP_UPDATE, 64'h5A5A_5A5A_5A5A_5A5A, 64'h00FF_FFFF_FFFF_FFFF, '1);

    // alternate fill and drain rounds
    for (int round = 0; round < 4; round++)
      for (int i = 0; i < 195; i++) pending_q.push_back(random_request(round % 2 == 0));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/srt_pkg.sv
src/srt_req_if.sv
src/srt_rsp_if.sv
src/srt_datapath.sv
src/srt_ctrl.sv
src/sorted_record_table_unit.sv
dv/sorted_record_table_unit_test.sv
